FILE: hdl/sirf_pkg.sv
`default_nettype none
package sirf_pkg;

   localparam int NumberWidth = 32;
   localparam int CharWidth   = 7;
   localparam int SymWidth    = 8;
   localparam int MaxSymbols  = 32;
   localparam int DigitWidth  = $clog2(MaxSymbols);
   localparam int CountWidth  = DigitWidth + 1;
   localparam int StepWidth   = $clog2(NumberWidth);
   localparam int CsrIdxWidth = 3;
   localparam int CsrWidth    = 64;
   localparam int SymRegs     = 4;
   localparam int SymPerReg   = CsrWidth / SymWidth;

   localparam logic [SymWidth-1:0] CharPlus  = 8'd43;
   localparam logic [SymWidth-1:0] CharMinus = 8'd45;
   localparam logic [SymWidth-1:0] PrintLow  = 8'd33;
   localparam logic [SymWidth-1:0] PrintHigh = 8'd126;
   localparam logic [CountWidth-1:0] MinRadix  = CountWidth'(2);
   localparam logic [CountWidth-1:0] MaxRadix  = CountWidth'(MaxSymbols);

   localparam logic [CsrIdxWidth-1:0] CsrDigitCount = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CsrSym0       = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CsrSym1       = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CsrSym2       = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CsrSym3       = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SIGN,
      ST_DIV,
      ST_POP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_in;
      logic chk_step;
      logic out_sign;
      logic div_step;
      logic pop;
      logic out_sym;
   } cmd_type;

   typedef struct packed {
      logic chk_fail;
      logic chk_done;
      logic neg;
      logic div_last;
      logic quo_next_zero;
      logic depth_zero;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

FILE: hdl/signed_integer_radix_formatter.sv
// signed integer to text in a configurable radix
//
// csr_*: write channel, csr_index 0 sets digit_count (the radix), 1..4 set
//   the alphabet bytes, symbol 0 in the lowest byte; other indexes ignored.
//   writes are taken every cycle and belong only to idle periods.
// req_*: one 32-bit two's complement number per beat.
// rsp_*: one character per beat, minus sign first for a negative number,
//   then digits most significant first; rsp_last marks the final one.
//   an invalid alphabet yields no beats at all for that number.
// steps per number, with n alphabet symbols and d digits:
//   alphabet check one symbol at a time, optional sign, then a serial
//   restoring divider, one quotient bit per step, run once per digit (d
//   times), then per digit a pop of the digit stack and a load of the
//   output register, then back to idle, where the next number is taken.
// one number in flight; req_ready is high only while the block is idle.
// a stalled rsp holds its beat in the output register and the sequencer
//   waits; the final beat may still be pending while the next number
//   is accepted.
// reset clears the configuration registers (radix 0, so nothing is
//   formatted until configured) and drops any pending beat.
`default_nettype none
module signed_integer_radix_formatter
   import sirf_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire  [CsrIdxWidth-1:0] csr_index,
   input  wire  [CsrWidth-1:0]    csr_wdata,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire  [NumberWidth-1:0] req_number,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output logic [CharWidth-1:0]   rsp_character,
   output logic                   rsp_last
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   sirf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sirf_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_number    (req_number),
      .rsp_ready     (rsp_ready),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_valid     (rsp_valid),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule
`default_nettype wire

FILE: hdl/sirf_ctrl.sv
`default_nettype none
module sirf_ctrl
   import sirf_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // one alphabet symbol per cycle, compared against all later ones
            if (sts.chk_fail) begin
               state_in = ST_IDLE;
            end else if (sts.chk_done) begin
               state_in = sts.neg ? ST_SIGN : ST_DIV;
            end else begin
               cmd.chk_step = 1'b1;
            end
         end
         ST_SIGN: begin
            if (sts.out_free) begin
               cmd.out_sign = 1'b1;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last && sts.quo_next_zero) begin
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            cmd.pop  = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.out_sym = 1'b1;
               state_in    = sts.depth_zero ? ST_IDLE : ST_POP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: hdl/sirf_dp.sv
`default_nettype none
module sirf_dp
   import sirf_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    csr_valid,
   input  wire  [CsrIdxWidth-1:0] csr_index,
   input  wire  [CsrWidth-1:0]    csr_wdata,
   input  wire  [NumberWidth-1:0] req_number,
   input  wire                    rsp_ready,
   input  cmd_type                cmd,
   output sts_type                sts,
   output logic                   rsp_valid,
   output logic [CharWidth-1:0]   rsp_character,
   output logic                   rsp_last
);

   logic [CountWidth-1:0]         digit_count_ff;
   logic [SymRegs*CsrWidth-1:0]   sym_ff;

   logic                          neg_ff;
   logic [NumberWidth-1:0]        quo_ff;
   logic [DigitWidth-1:0]         rem_ff;
   logic [StepWidth-1:0]          bit_ff;
   logic [CountWidth-1:0]         depth_ff;
   logic [DigitWidth-1:0]         chk_idx_ff;
   logic [DigitWidth-1:0]         rd_data_ff;

   logic                          rsp_valid_ff;
   logic [CharWidth-1:0]          rsp_character_ff;
   logic                          rsp_last_ff;

   logic [DigitWidth-1:0]         stack_mem [MaxSymbols];

   logic [SymWidth-1:0]           sym_byte;
   logic [SymWidth-1:0]           out_byte;
   logic                          sym_bad;
   logic                          sym_dup;
   logic                          count_bad;
   logic [CountWidth-1:0]         rem_sh;
   logic [CountWidth-1:0]         rem_sub;
   logic                          rem_ge;
   logic [DigitWidth-1:0]         rem_next;
   logic [NumberWidth-1:0]        quo_next;
   logic [DigitWidth-1:0]         rd_addr;
   logic [NumberWidth-1:0]        mag;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         digit_count_ff <= '0;
         sym_ff         <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CsrDigitCount: digit_count_ff <= csr_wdata[CountWidth-1:0];
            CsrSym0:       sym_ff[0*CsrWidth +: CsrWidth] <= csr_wdata;
            CsrSym1:       sym_ff[1*CsrWidth +: CsrWidth] <= csr_wdata;
            CsrSym2:       sym_ff[2*CsrWidth +: CsrWidth] <= csr_wdata;
            CsrSym3:       sym_ff[3*CsrWidth +: CsrWidth] <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // symbol lookups: one for the alphabet check, one for the output
   assign sym_byte = sym_ff[{chk_idx_ff, 3'b000} +: SymWidth];
   assign out_byte = sym_ff[{rd_data_ff, 3'b000} +: SymWidth];

   assign count_bad = (digit_count_ff < MinRadix) || (digit_count_ff > MaxRadix);
   assign sym_bad   = (sym_byte == CharPlus) || (sym_byte == CharMinus) ||
                      (sym_byte < PrintLow) || (sym_byte > PrintHigh);

   always_comb begin
      sym_dup = 1'b0;
      for (int j = 0; j < MaxSymbols; j++) begin
         if ((CountWidth'(j) > {1'b0, chk_idx_ff}) && (CountWidth'(j) < digit_count_ff) &&
             (sym_ff[j*SymWidth +: SymWidth] == sym_byte)) begin
            sym_dup = 1'b1;
         end
      end
   end

   // restoring division, one quotient bit per cycle
   assign rem_sh   = {rem_ff, quo_ff[NumberWidth-1]};
   assign rem_ge   = rem_sh >= digit_count_ff;
   assign rem_sub  = rem_sh - digit_count_ff;
   assign rem_next = rem_ge ? rem_sub[DigitWidth-1:0] : rem_sh[DigitWidth-1:0];
   assign quo_next = {quo_ff[NumberWidth-2:0], rem_ge};

   assign rd_addr = DigitWidth'(depth_ff - CountWidth'(1));
   assign mag     = req_number[NumberWidth-1] ? (~req_number + NumberWidth'(1)) : req_number;

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         neg_ff     <= req_number[NumberWidth-1];
         quo_ff     <= mag;
         rem_ff     <= '0;
         bit_ff     <= '0;
         depth_ff   <= '0;
         chk_idx_ff <= '0;
      end else begin
         if (cmd.chk_step) begin
            chk_idx_ff <= chk_idx_ff + DigitWidth'(1);
         end
         if (cmd.div_step) begin
            bit_ff <= bit_ff + StepWidth'(1);
            quo_ff <= quo_next;
            if (sts.div_last) begin
               rem_ff   <= '0;
               depth_ff <= depth_ff + CountWidth'(1);
            end else begin
               rem_ff <= rem_next;
            end
         end
         if (cmd.pop) begin
            depth_ff <= depth_ff - CountWidth'(1);
         end
      end
   end

   // digit stack, least significant digit pushed first
   always_ff @(posedge clock) begin
      if (cmd.div_step && sts.div_last) begin
         stack_mem[depth_ff[DigitWidth-1:0]] <= rem_next;
      end
      if (cmd.pop) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_sign || cmd.out_sym) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_sign) begin
         rsp_character_ff <= CharMinus[CharWidth-1:0];
         rsp_last_ff      <= 1'b0;
      end else if (cmd.out_sym) begin
         rsp_character_ff <= out_byte[CharWidth-1:0];
         rsp_last_ff      <= sts.depth_zero;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

   always_comb begin
      sts.chk_fail      = count_bad || sym_bad || sym_dup;
      sts.chk_done      = {1'b0, chk_idx_ff} == (digit_count_ff - CountWidth'(1));
      sts.neg           = neg_ff;
      sts.div_last      = &bit_ff;
      sts.quo_next_zero = quo_next == '0;
      sts.depth_zero    = depth_ff == '0;
      sts.out_free      = !rsp_valid_ff || rsp_ready;
   end

endmodule
`default_nettype wire

FILE: hdl/sirf_checker.sv
`default_nettype none
module sirf_checker
   import sirf_pkg::*;
(
   input wire                   clock,
   input wire                   reset,
   input wire                   req_valid,
   input wire                   req_ready,
   input wire                   rsp_valid,
   input wire                   rsp_ready,
   input wire [CharWidth-1:0]   rsp_character,
   input wire                   rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_character) && $stable(rsp_last))
      else $error("rsp beat changed while stalled");

   a_rsp_printable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_character >= PrintLow[CharWidth-1:0]) &&
                    (rsp_character <= PrintHigh[CharWidth-1:0]))
      else $error("rsp character not printable");

   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_character == CharMinus[CharWidth-1:0]) |-> !rsp_last)
      else $error("minus sign marked as last");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req taken while number in progress");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp beat right after reset");

endmodule

bind signed_integer_radix_formatter sirf_checker u_sirf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_character (rsp_character),
   .rsp_last      (rsp_last)
);
`default_nettype wire

FILE: dv/signed_integer_radix_formatter_checker.sv
`default_nettype none
module sirf_text_checker
   import sirf_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    csr_valid,
   input  wire                    csr_ready,
   input  wire  [CsrIdxWidth-1:0] csr_index,
   input  wire  [CsrWidth-1:0]    csr_wdata,
   input  wire                    req_valid,
   input  wire                    req_ready,
   input  wire  [NumberWidth-1:0] req_number,
   input  wire                    rsp_valid,
   input  wire                    rsp_ready,
   input  wire  [CharWidth-1:0]   rsp_character,
   input  wire                    rsp_last,
   output int                     failures,
   output int                     outstanding
);

   typedef struct packed {
      logic [CharWidth-1:0] character;
      logic                 last;
   } text_beat_type;

   text_beat_type         expected_text [$];
   text_beat_type         oldest;
   logic [CountWidth-1:0] radix_reg;
   logic [CsrWidth-1:0]   symbol_regs [SymRegs];
   int                    mismatch_total = 0;

   function automatic logic [SymWidth-1:0] symbol_at(input int unsigned pos);
      return symbol_regs[pos / SymPerReg][(pos % SymPerReg) * SymWidth +: SymWidth];
   endfunction

   function automatic bit alphabet_valid();
      logic [SymWidth-1:0] sym;
      int                  i;
      int                  j;
      if (radix_reg < MinRadix || radix_reg > MaxRadix) return 1'b0;
      for (i = 0; i < radix_reg; i++) begin
         sym = symbol_at(i);
         if (sym == CharPlus || sym == CharMinus) return 1'b0;
         if (sym < PrintLow || sym > PrintHigh) return 1'b0;
         // any pair, not only neighbors
         for (j = i + 1; j < radix_reg; j++) begin
            if (symbol_at(j) == sym) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic void format_number(input logic [NumberWidth-1:0] number);
      logic [NumberWidth-1:0] magnitude;
      logic [NumberWidth-1:0] base;
      logic [DigitWidth-1:0]  digits [NumberWidth];
      logic [SymWidth-1:0]    sym;
      int                     depth;
      if (!alphabet_valid()) return;
      base  = NumberWidth'(radix_reg);
      depth = 0;
      if (number[NumberWidth-1]) begin
         expected_text.push_back('{CharWidth'(CharMinus), 1'b0});
      end
      // unsigned magnitude, so the most negative value wraps onto itself
      magnitude = number[NumberWidth-1] ? (~number + 1'b1) : number;
      // zero still gives one digit
      do begin
         digits[depth] = DigitWidth'(magnitude % base);
         magnitude     = magnitude / base;
         depth++;
      end while (magnitude != 0);
      while (depth > 0) begin
         depth--;
         sym = symbol_at(digits[depth]);
         expected_text.push_back('{CharWidth'(sym), depth == 0});
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         radix_reg = '0;
         foreach (symbol_regs[r]) symbol_regs[r] = '0;
         expected_text.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_text.size() == 0) begin
               $error("beat with no text expected: character %0d last %0d",
                      rsp_character, rsp_last);
               mismatch_total++;
            end else begin
               oldest = expected_text.pop_front();
               if (rsp_character !== oldest.character) begin
                  $error("character: expected %0d, actual %0d",
                         oldest.character, rsp_character);
                  mismatch_total++;
               end
               if (rsp_last !== oldest.last) begin
                  $error("last: expected %0d, actual %0d", oldest.last, rsp_last);
                  mismatch_total++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CsrDigitCount) begin
               radix_reg = csr_wdata[CountWidth-1:0];
            end else if (csr_index <= CsrSym3) begin
               symbol_regs[csr_index - CsrSym0] = csr_wdata;
            end
         end
         if (req_valid && req_ready) format_number(req_number);
      end
      failures    <= mismatch_total;
      outstanding <= expected_text.size();
   end

endmodule
`default_nettype wire

FILE: dv/tb_signed_integer_radix_formatter.sv
`default_nettype none
module tb_signed_integer_radix_formatter;
   import sirf_pkg::*;

   localparam int DrainCycles = 1200;
   localparam int PhaseItems  = 45;
   localparam int RandomItems = 270;

   typedef enum int {
      DEFECT_NONE,
      DEFECT_PLUS,
      DEFECT_MINUS,
      DEFECT_BELOW,
      DEFECT_ABOVE,
      DEFECT_TOP_BIT,
      DEFECT_ZERO,
      DEFECT_REPEAT,
      DEFECT_REPEAT_FAR
   } alphabet_defect_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [CsrWidth-1:0]    csr_wdata;
   logic                   req_valid;
   logic                   req_ready;
   logic [NumberWidth-1:0] req_number;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [CharWidth-1:0]   rsp_character;
   logic                   rsp_last;
   int                     failures;
   int                     outstanding;
   bit                     steady;
   logic [SymWidth-1:0]    symbol_bytes [MaxSymbols];

   signed_integer_radix_formatter dut (
      .clock, .reset,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .req_valid, .req_ready, .req_number,
      .rsp_valid, .rsp_ready, .rsp_character, .rsp_last
   );

   sirf_text_checker watch (
      .clock, .reset,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .req_valid, .req_ready, .req_number,
      .rsp_valid, .rsp_ready, .rsp_character, .rsp_last,
      .failures, .outstanding
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = steady || ($urandom_range(99) >= 32);
      end
   end

   task automatic write_register(input logic [CsrIdxWidth-1:0] index,
                                 input logic [CsrWidth-1:0] data);
      csr_index = index;
      csr_wdata = data;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic send_number(input logic [NumberWidth-1:0] value);
      while (!steady && $urandom_range(99) < 32) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_number = value;
      req_valid  = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // wait for all text, then let an item with no text finish
   task automatic settle();
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic load_alphabet(input int count);
      logic [CsrWidth-1:0] word;
      int                  i;
      int                  j;
      // indexes past the last register must change nothing
      for (i = CsrSym3 + 1; i < (1 << CsrIdxWidth); i++) begin
         write_register(CsrIdxWidth'(i), {$urandom, $urandom});
      end
      word = {$urandom, $urandom};
      word[CountWidth-1:0] = CountWidth'(count);
      write_register(CsrDigitCount, word);
      for (i = 0; i < SymRegs; i++) begin
         for (j = 0; j < SymPerReg; j++) begin
            word[j*SymWidth +: SymWidth] = symbol_bytes[i*SymPerReg + j];
         end
         write_register(CsrSym0 + CsrIdxWidth'(i), word);
      end
      csr_valid = 1'b0;
   endtask

   task automatic configure(input int count, input alphabet_defect_type defect);
      logic [SymWidth-1:0] pool [$];
      int                  pick;
      int                  i;
      int                  j;
      pool.delete();
      for (i = PrintLow; i <= PrintHigh; i++) begin
         if (i != CharPlus && i != CharMinus) pool.push_back(SymWidth'(i));
      end
      for (i = 0; i < MaxSymbols; i++) begin
         pick = $urandom_range(pool.size() - 1);
         symbol_bytes[i] = pool[pick];
         pool.delete(pick);
      end
      // bytes past the radix are junk
      for (i = count; i < MaxSymbols; i++) symbol_bytes[i] = SymWidth'($urandom);
      if (count >= MinRadix && count <= MaxSymbols) begin
         i = $urandom_range(count - 1);
         case (defect)
            DEFECT_PLUS:    symbol_bytes[i] = CharPlus;
            DEFECT_MINUS:   symbol_bytes[i] = CharMinus;
            DEFECT_BELOW:   symbol_bytes[i] = SymWidth'($urandom_range(PrintLow - 1));
            DEFECT_ABOVE:   symbol_bytes[i] = PrintHigh + 1'b1;
            DEFECT_TOP_BIT: symbol_bytes[i] = SymWidth'($urandom_range(255, 128));
            DEFECT_ZERO:    symbol_bytes[i] = '0;
            DEFECT_REPEAT: begin
               j = $urandom_range(count - 1);
               if (j == i) j = (i + 1) % count;
               symbol_bytes[j] = symbol_bytes[i];
            end
            DEFECT_REPEAT_FAR: symbol_bytes[count-1] = symbol_bytes[0];
            default: ;
         endcase
      end
      load_alphabet(count);
   endtask

   function automatic logic [NumberWidth-1:0] pick_number(input int base);
      logic [63:0]            power;
      logic [NumberWidth-1:0] value;
      int                     k;
      case ($urandom_range(5))
         0, 1: value = $urandom;
         2: value = $urandom_range(3 * base);
         3: begin
            // near a power of the radix, where the digit count steps
            power = 1;
            k = $urandom_range(31);
            repeat (k) if (power * base <= 64'h8000_0000) power = power * base;
            value = power[NumberWidth-1:0] - $urandom_range(1);
         end
         4: begin
            case ($urandom_range(3))
               0:       value = 32'h8000_0000;
               1:       value = 32'h7fff_ffff;
               2:       value = '0;
               default: value = 32'h8000_0001;
            endcase
         end
         default: value = $urandom_range(255);
      endcase
      if ($urandom_range(1)) value = -value;
      return value;
   endfunction

   initial begin
      int                  i;
      int                  c;
      int                  count;
      int                  sent;
      int                  phase;
      alphabet_defect_type defect;
      reset      = 1'b1;
      csr_valid  = 1'b0;
      csr_index  = CsrDigitCount;
      csr_wdata  = '0;
      req_valid  = 1'b0;
      req_number = '0;
      steady     = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // radix is zero out of reset, so nothing comes back
      send_number($urandom);
      settle();

      // decimal, with junk past the radix
      for (i = 0; i < 10; i++) symbol_bytes[i] = SymWidth'(48 + i);
      for (i = 10; i < MaxSymbols; i++) symbol_bytes[i] = SymWidth'($urandom);
      symbol_bytes[10] = CharPlus;
      symbol_bytes[11] = symbol_bytes[0];
      load_alphabet(10);
      send_number(32'd0);
      send_number(32'd1);
      send_number(32'hffff_ffff);
      send_number(32'h7fff_ffff);
      send_number(32'h8000_0000);
      send_number(32'd1234567890);
      settle();

      // radix 2: longest text
      configure(MinRadix, DEFECT_NONE);
      send_number(32'h8000_0000);
      send_number(32'hffff_ffff);
      send_number(32'h7fff_ffff);
      settle();

      // radix 32 with both printable extremes
      c = PrintLow;
      for (i = 0; i < MaxSymbols - 1; i++) begin
         while (c == CharPlus || c == CharMinus) c++;
         symbol_bytes[i] = SymWidth'(c);
         c++;
      end
      symbol_bytes[MaxSymbols-1] = PrintHigh;
      load_alphabet(MaxSymbols);
      send_number(32'h8000_0000);
      send_number(32'h7fff_ffff);
      send_number(32'd31);
      send_number(32'd32);
      settle();

      // broken alphabets
      configure(1, DEFECT_NONE);
      send_number($urandom);
      settle();
      configure(MaxSymbols + 1, DEFECT_NONE);
      send_number($urandom);
      settle();
      configure((1 << CountWidth) - 1, DEFECT_NONE);
      send_number($urandom);
      settle();
      for (i = DEFECT_PLUS; i <= DEFECT_REPEAT_FAR; i++) begin
         configure(12, alphabet_defect_type'(i));
         send_number($urandom);
         settle();
      end

      sent  = 0;
      phase = 0;
      while (sent < RandomItems) begin
         steady = (phase == 2);
         if ($urandom_range(5) == 0 && phase != 2) begin
            defect = alphabet_defect_type'($urandom_range(DEFECT_REPEAT_FAR));
            if (defect == DEFECT_NONE) begin
               count = $urandom_range(1) ? $urandom_range(1)
                                         : $urandom_range((1 << CountWidth) - 1, 33);
            end else begin
               count = $urandom_range(MaxSymbols, 3);
            end
            configure(count, defect);
            repeat (3) send_number($urandom);
         end else begin
            case ($urandom_range(3))
               0:       count = MinRadix;
               1:       count = MaxSymbols;
               default: count = $urandom_range(MaxSymbols - 1, 3);
            endcase
            configure(count, DEFECT_NONE);
            repeat (PhaseItems) send_number(pick_number(count));
            sent += PhaseItems;
         end
         settle();
         phase++;
      end
      steady = 1'b0;

      if (failures == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #(8 * 3_000_000);
      $display("tb: failure");
      $finish;
   end

endmodule
`default_nettype wire
